[src/clrt_pkg.sv]
// Shared operation codes and controller/datapath handshake types for the lease table.
package clrt_pkg;

  localparam logic [2:0] OP_ACQUIRE = 3'd0;
  localparam logic [2:0] OP_RELEASE = 3'd1;
  localparam logic [2:0] OP_MOVE    = 3'd2;
  localparam logic [2:0] OP_REFRESH = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;
  localparam logic [2:0] OP_QUERY   = 3'd5;

  typedef struct packed {
    logic capture;      // latch the input item and read lease and owner entries
    logic follow_read;  // read the owner entries named by the held lease
    logic commit_look;  // finish an item that needs no owner cleanup
    logic commit_drop;  // clear the lease and the owner entries that still name the agent
    logic sweep_write;  // write one row of the clearing pass
    logic load_out;     // move the finished result into the output register
  } cmd_t;

  typedef struct packed {
    logic in_clear;     // the offered item is a clear-all
    logic needs_drop;   // the captured item removes a held lease
    logic sweep_last;   // the clearing pass is on its last row
  } status_t;

endpackage

[src/clrt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module clrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/clrt_ctrl.sv]
// Controller state machine that sequences lookups, cleanup, the clearing pass and the output.
module clrt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  clrt_pkg::status_t status,
  output clrt_pkg::cmd_t    cmd
);
  import clrt_pkg::*;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_LOOK,
    S_FOLLOW,
    S_RESP
  } state_t;

  state_t state;
  logic   from_clear;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_SWEEP:  cmd.sweep_write = 1'b1;
      S_IDLE:   cmd.capture     = in_valid;
      S_LOOK: begin
        cmd.follow_read = status.needs_drop;
        cmd.commit_look = !status.needs_drop;
      end
      S_FOLLOW: cmd.commit_drop = 1'b1;
      S_RESP:   cmd.load_out    = out_free;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      from_clear <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_SWEEP: begin
          if (status.sweep_last) begin
            state <= from_clear ? S_RESP : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            if (status.in_clear) begin
              from_clear <= 1'b1;
              state      <= S_SWEEP;
            end else begin
              state <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          state <= status.needs_drop ? S_FOLLOW : S_RESP;
        end
        S_FOLLOW: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            from_clear <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/clrt_datapath.sv]
// Datapath: lease and owner memories, item registers, decisions and the output register.
module clrt_datapath #(
  parameter int NUM_AGENTS = 64,
  parameter int NUM_CELLS  = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  clrt_pkg::cmd_t                cmd,
  output clrt_pkg::status_t             status,
  input  logic [2:0]                    operation,
  input  logic [$clog2(NUM_AGENTS)-1:0] agent,
  input  logic [$clog2(NUM_CELLS)-1:0]  term_cell,
  input  logic [$clog2(NUM_CELLS)-1:0]  inner_cell,
  input  logic [$clog2(NUM_CELLS)-1:0]  destination,
  input  logic                          agent_active,
  input  logic [$clog2(NUM_CELLS)-1:0]  agent_position,
  input  logic [$clog2(NUM_CELLS)-1:0]  agent_goal,
  input  logic [$clog2(NUM_CELLS)-1:0]  agent_next_cell,
  output logic                          granted,
  output logic                          return_valid,
  output logic [$clog2(NUM_CELLS)-1:0]  return_position,
  output logic                          lease_dropped
);
  import clrt_pkg::*;

  localparam int AGENT_W     = $clog2(NUM_AGENTS);
  localparam int CELL_W      = $clog2(NUM_CELLS);
  localparam int OWNER_W     = AGENT_W + 1;
  localparam int LEASE_W     = 1 + 2 * CELL_W;
  localparam int SWEEP_DEPTH = (NUM_AGENTS > NUM_CELLS) ? NUM_AGENTS : NUM_CELLS;
  localparam int SWEEP_W     = $clog2(SWEEP_DEPTH);

  localparam logic [AGENT_W:0] AGENT_LIMIT = (AGENT_W + 1)'(NUM_AGENTS);
  localparam logic [CELL_W:0]  CELL_LIMIT  = (CELL_W + 1)'(NUM_CELLS);
  localparam logic [SWEEP_W:0] SWEEP_AGENT = (SWEEP_W + 1)'(NUM_AGENTS);
  localparam logic [SWEEP_W:0] SWEEP_CELL  = (SWEEP_W + 1)'(NUM_CELLS);
  localparam logic [SWEEP_W-1:0] SWEEP_LAST = SWEEP_W'(SWEEP_DEPTH - 1);

  // Captured item.
  logic [2:0]         op_q;
  logic [AGENT_W-1:0] agent_q;
  logic [CELL_W-1:0]  term_q;
  logic [CELL_W-1:0]  inw_q;
  logic [CELL_W-1:0]  dest_q;
  logic               active_q;
  logic [CELL_W-1:0]  pos_q;
  logic [CELL_W-1:0]  goal_q;
  logic [CELL_W-1:0]  next_q;

  // Clearing pass row counter.
  logic [SWEEP_W-1:0] sweep_cnt;
  logic               sweep_agent_row;
  logic               sweep_cell_row;

  // Memory ports.
  logic               lease_we;
  logic [AGENT_W-1:0] lease_waddr;
  logic [LEASE_W-1:0] lease_wdata;
  logic [LEASE_W-1:0] lease_rdata;
  logic               term_we;
  logic [CELL_W-1:0]  term_waddr;
  logic [OWNER_W-1:0] term_wdata;
  logic [CELL_W-1:0]  term_raddr;
  logic [OWNER_W-1:0] term_rdata;
  logic               inw_we;
  logic [CELL_W-1:0]  inw_waddr;
  logic [OWNER_W-1:0] inw_wdata;
  logic [CELL_W-1:0]  inw_raddr;
  logic [OWNER_W-1:0] inw_rdata;
  logic               owner_re;

  // Decisions.
  logic              agent_ok;
  logic              held;
  logic [CELL_W-1:0] lease_term;
  logic [CELL_W-1:0] lease_inw;
  logic              term_free;
  logic              inw_free;
  logic              term_mine;
  logic              inw_mine;
  logic              cells_ok;
  logic              dest_ok;
  logic              acq_grant;
  logic              acq_write;
  logic              move_grant;
  logic              keep;

  // Result of the current item.
  logic              res_granted;
  logic              res_rvalid;
  logic [CELL_W-1:0] res_rpos;
  logic              res_dropped;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q     <= operation;
      agent_q  <= agent;
      term_q   <= term_cell;
      inw_q    <= inner_cell;
      dest_q   <= destination;
      active_q <= agent_active;
      pos_q    <= agent_position;
      goal_q   <= agent_goal;
      next_q   <= agent_next_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep_write) begin
      sweep_cnt <= (sweep_cnt == SWEEP_LAST) ? '0 : sweep_cnt + 1'b1;
    end
  end

  assign sweep_agent_row = {1'b0, sweep_cnt} < SWEEP_AGENT;
  assign sweep_cell_row  = {1'b0, sweep_cnt} < SWEEP_CELL;

  assign held       = agent_ok && lease_rdata[LEASE_W-1];
  assign lease_term = lease_rdata[2*CELL_W-1:CELL_W];
  assign lease_inw  = lease_rdata[CELL_W-1:0];
  assign agent_ok   = {1'b0, agent_q} < AGENT_LIMIT;

  // Owner entries hold a valid bit over the agent id; a clear valid bit means no owner.
  assign term_mine = term_rdata[OWNER_W-1] && (term_rdata[AGENT_W-1:0] == agent_q);
  assign inw_mine  = inw_rdata[OWNER_W-1] && (inw_rdata[AGENT_W-1:0] == agent_q);
  assign term_free = !term_rdata[OWNER_W-1] || term_mine;
  assign inw_free  = !inw_rdata[OWNER_W-1] || inw_mine;

  assign cells_ok   = ({1'b0, term_q} < CELL_LIMIT) && ({1'b0, inw_q} < CELL_LIMIT);
  assign dest_ok    = {1'b0, dest_q} < CELL_LIMIT;
  assign acq_write  = agent_ok && cells_ok && !held && term_free && inw_free;
  assign acq_grant  = held ? ((lease_term == term_q) && (lease_inw == inw_q)) : acq_write;
  assign move_grant = !dest_ok || (term_free && inw_free);

  // The lease stays while the agent approaches from the inward cell or stands on the terminal.
  assign keep = active_q && (((pos_q == lease_inw) && (goal_q == lease_term) &&
                              (next_q == lease_term)) || (pos_q == lease_term));

  assign status.in_clear   = (operation == OP_CLEAR);
  assign status.needs_drop = held && ((op_q == OP_RELEASE) || ((op_q == OP_REFRESH) && !keep));
  assign status.sweep_last = (sweep_cnt == SWEEP_LAST);

  assign owner_re = cmd.capture || cmd.follow_read;

  always_comb begin
    priority if (cmd.follow_read) begin
      term_raddr = lease_term;
      inw_raddr  = lease_inw;
    end else if (operation == OP_MOVE) begin
      term_raddr = destination;
      inw_raddr  = destination;
    end else begin
      term_raddr = term_cell;
      inw_raddr  = inner_cell;
    end
  end

  always_comb begin
    lease_we    = 1'b0;
    lease_waddr = agent_q;
    lease_wdata = {1'b1, term_q, inw_q};
    term_we     = 1'b0;
    term_waddr  = term_q;
    term_wdata  = {1'b1, agent_q};
    inw_we      = 1'b0;
    inw_waddr   = inw_q;
    inw_wdata   = {1'b1, agent_q};
    priority if (cmd.sweep_write) begin
      lease_we    = sweep_agent_row;
      lease_waddr = sweep_cnt[AGENT_W-1:0];
      lease_wdata = '0;
      term_we     = sweep_cell_row;
      term_waddr  = sweep_cnt[CELL_W-1:0];
      term_wdata  = '0;
      inw_we      = sweep_cell_row;
      inw_waddr   = sweep_cnt[CELL_W-1:0];
      inw_wdata   = '0;
    end else if (cmd.commit_look) begin
      lease_we = (op_q == OP_ACQUIRE) && acq_write;
      term_we  = (op_q == OP_ACQUIRE) && acq_write;
      inw_we   = (op_q == OP_ACQUIRE) && acq_write;
    end else if (cmd.commit_drop) begin
      lease_we    = 1'b1;
      lease_wdata = {1'b0, lease_term, lease_inw};
      term_we     = term_mine;
      term_waddr  = lease_term;
      term_wdata  = '0;
      inw_we      = inw_mine;
      inw_waddr   = lease_inw;
      inw_wdata   = '0;
    end else begin
      lease_we = 1'b0;
    end
  end

  clrt_ram #(.WIDTH(LEASE_W), .DEPTH(NUM_AGENTS)) u_lease_ram (
    .clk   (clk),
    .we    (lease_we),
    .waddr (lease_waddr),
    .wdata (lease_wdata),
    .re    (cmd.capture),
    .raddr (agent),
    .rdata (lease_rdata)
  );

  clrt_ram #(.WIDTH(OWNER_W), .DEPTH(NUM_CELLS)) u_term_owner_ram (
    .clk   (clk),
    .we    (term_we),
    .waddr (term_waddr),
    .wdata (term_wdata),
    .re    (owner_re),
    .raddr (term_raddr),
    .rdata (term_rdata)
  );

  clrt_ram #(.WIDTH(OWNER_W), .DEPTH(NUM_CELLS)) u_inw_owner_ram (
    .clk   (clk),
    .we    (inw_we),
    .waddr (inw_waddr),
    .wdata (inw_wdata),
    .re    (owner_re),
    .raddr (inw_raddr),
    .rdata (inw_rdata)
  );

  // A clear-all leaves the zero result written at capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_granted <= 1'b0;
      res_rvalid  <= 1'b0;
      res_rpos    <= '0;
      res_dropped <= 1'b0;
    end else if (cmd.commit_look) begin
      res_granted <= ((op_q == OP_ACQUIRE) && acq_grant) || ((op_q == OP_MOVE) && move_grant);
      res_rvalid  <= (op_q == OP_QUERY) && held && (pos_q == lease_term);
      res_rpos    <= ((op_q == OP_QUERY) && held && (pos_q == lease_term)) ? lease_inw : '0;
      res_dropped <= 1'b0;
    end else if (cmd.commit_drop) begin
      res_dropped <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      granted         <= res_granted;
      return_valid    <= res_rvalid;
      return_position <= res_rpos;
      lease_dropped   <= res_dropped;
    end
  end

endmodule

[src/cell_lease_reservation_table.sv]
// Top level: an item passes the look-up and result states into the output register,
// with one more owner read before the write-back when a release or refresh drops a held lease.
// The controller takes one item at a time; in_stall stays high until the result is loaded.
// A clear-all walks max(NUM_AGENTS, NUM_CELLS) rows, one per cycle, before its result.
// After rst the same clearing pass runs with in_stall high;
// rst is synchronous and active high.
module cell_lease_reservation_table #(
  parameter int NUM_AGENTS = 64,
  parameter int NUM_CELLS  = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    operation,
  input  logic [$clog2(NUM_AGENTS)-1:0] agent,
  input  logic [$clog2(NUM_CELLS)-1:0]  term_cell,
  input  logic [$clog2(NUM_CELLS)-1:0]  inner_cell,
  input  logic [$clog2(NUM_CELLS)-1:0]  destination,
  input  logic                          agent_active,
  input  logic [$clog2(NUM_CELLS)-1:0]  agent_position,
  input  logic [$clog2(NUM_CELLS)-1:0]  agent_goal,
  input  logic [$clog2(NUM_CELLS)-1:0]  agent_next_cell,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          granted,
  output logic                          return_valid,
  output logic [$clog2(NUM_CELLS)-1:0]  return_position,
  output logic                          lease_dropped
);
  import clrt_pkg::*;

  cmd_t    cmd;
  status_t status;

  clrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  clrt_datapath #(
    .NUM_AGENTS (NUM_AGENTS),
    .NUM_CELLS  (NUM_CELLS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .operation       (operation),
    .agent           (agent),
    .term_cell       (term_cell),
    .inner_cell      (inner_cell),
    .destination     (destination),
    .agent_active    (agent_active),
    .agent_position  (agent_position),
    .agent_goal      (agent_goal),
    .agent_next_cell (agent_next_cell),
    .granted         (granted),
    .return_valid    (return_valid),
    .return_position (return_position),
    .lease_dropped   (lease_dropped)
  );

endmodule
